>>> rtl/pfra_pkg.sv
// Shared constants and types for the page frame reference count allocator.
// Used by the allocator top level, the reply checker and the test top; depends on nothing else.
package pfra_pkg;

  localparam int PAGES    = 4096;
  localparam int PAGE_W   = $clog2(PAGES);
  localparam int SPAN_W   = PAGE_W + 1;
  localparam int REGIONS  = 4;
  localparam int REG_W    = $clog2(REGIONS);
  localparam int CFG_W    = 13;
  localparam int IDX_W    = 4;
  localparam int REF_W    = 8;

  localparam logic [REF_W-1:0] CNT_SAT      = 8'hfe;
  localparam logic [REF_W-1:0] CNT_RESERVED = 8'hff;

  typedef enum logic [1:0] {
    OP_ALLOC_ONE = 2'd0,
    OP_ALLOC_RUN = 2'd1,
    OP_ADD_REF   = 2'd2,
    OP_DROP_REF  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_PAGE = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  localparam logic [IDX_W-1:0] CFG_REGS = IDX_W'(2 * REGIONS);

  // Region end clipped to the size of the page store.
  function automatic logic [SPAN_W-1:0] clip_end(input logic [CFG_W-1:0] e);
    logic [SPAN_W-1:0] r;
    if (CFG_W'(e) > CFG_W'(PAGES)) begin
      r = SPAN_W'(PAGES);
    end else begin
      r = SPAN_W'(e);
    end
    return r;
  endfunction

endpackage

>>> rtl/page_frame_refcount_allocator.sv
// Page frame allocator with one reference count byte per page, kept in a RAM.
// Depends on pfra_pkg and pfra_ram.
//
// Usage: a request is taken when start is high and busy is low; it carries
// op, page and count. Exactly one result beat follows, shown for one cycle
// with done high: status, page_out and refs_left. The receiver cannot stall,
// and the block takes one request at a time.
// Add and drop reference pass through a read of the count RAM, a modify and
// write back, and the result register before done.
// Alloc one and alloc run scan the count RAM one page per cycle, region by
// region, then mark the pages of the run found. Overlapping regions are each
// scanned in full; the single RAM read port serves the whole scan.
// Region registers are written through the cfg channel, which is always
// ready; they may be changed only while no request is in flight.
// After reset a clearing pass writes zero into all PAGES counts, one per
// cycle; busy stays high until the pass ends, before the first request.
module page_frame_refcount_allocator
  import pfra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [PAGE_W-1:0] page,
  input  logic [CFG_W-1:0]  count,
  output logic              done,
  output logic [1:0]        status,
  output logic [PAGE_W-1:0] page_out,
  output logic [REF_W-1:0]  refs_left,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_READ,
    S_UPDATE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  region_first [REGIONS];
  logic [CFG_W-1:0]  region_end   [REGIONS];

  logic [PAGE_W-1:0] clr_addr;
  op_t               op_q;
  logic [PAGE_W-1:0] page_q;
  logic [SPAN_W-1:0] need;
  logic [REG_W-1:0]  region;
  logic [SPAN_W-1:0] scan_addr;
  logic              chk_valid;
  logic [PAGE_W-1:0] chk_addr;
  logic [SPAN_W-1:0] run_len;
  logic [PAGE_W-1:0] run_start;
  logic [PAGE_W-1:0] fill_addr;
  logic [SPAN_W-1:0] fill_left;

  logic              ram_wr_en;
  logic [PAGE_W-1:0] ram_wr_addr;
  logic [REF_W-1:0]  ram_wr_data;
  logic [PAGE_W-1:0] ram_rd_addr;
  logic [REF_W-1:0]  ram_rd_data;

  logic [SPAN_W-1:0] scan_hi;
  logic              scan_more;
  logic              page_free;
  logic [PAGE_W-1:0] cand_start;
  logic              run_found;
  logic              usable;
  logic              upd_bad;
  logic              upd_sat;
  logic [REF_W-1:0]  upd_value;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGIONS; i++) begin
        region_first[i] <= '0;
        region_end[i]   <= '0;
      end
    end else if (cfg_valid && cfg_ready && cfg_index < CFG_REGS) begin
      if (cfg_index[0]) begin
        region_end[cfg_index[REG_W:1]] <= cfg_data;
      end else begin
        region_first[cfg_index[REG_W:1]] <= cfg_data;
      end
    end
  end

  always_comb begin
    usable = 1'b0;
    for (int i = 0; i < REGIONS; i++) begin
      if (SPAN_W'(page_q) >= SPAN_W'(region_first[i]) &&
          SPAN_W'(page_q) < clip_end(region_end[i])) begin
        usable = 1'b1;
      end
    end
  end

  assign scan_hi    = clip_end(region_end[region]);
  assign scan_more  = (scan_addr < scan_hi);
  assign page_free  = chk_valid && (ram_rd_data == '0);
  assign cand_start = (run_len == '0) ? chk_addr : run_start;
  assign run_found  = page_free && (SPAN_W'(run_len + 1'b1) == need);

  assign upd_bad   = !usable || (ram_rd_data == '0) || (ram_rd_data == CNT_RESERVED);
  assign upd_sat   = (op_q == OP_ADD_REF) && (ram_rd_data == CNT_SAT);
  assign upd_value = (op_q == OP_ADD_REF) ? REF_W'(ram_rd_data + 1'b1)
                                          : REF_W'(ram_rd_data - 1'b1);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_addr;
    ram_wr_data = '0;
    ram_rd_addr = page_q;
    unique case (state)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      S_FILL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = fill_addr;
        ram_wr_data = REF_W'(1);
      end
      S_UPDATE: begin
        ram_wr_en   = !upd_bad && !upd_sat;
        ram_wr_addr = page_q;
        ram_wr_data = upd_value;
      end
      S_SCAN: begin
        ram_rd_addr = scan_addr[PAGE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  pfra_ram #(
    .WIDTH(REF_W),
    .DEPTH(PAGES)
  ) u_counts (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      done      <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= PAGE_W'(clr_addr + 1'b1);
          if (clr_addr == PAGE_W'(PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q      <= op_t'(op);
            page_q    <= page;
            need      <= (op_t'(op) == OP_ALLOC_ONE) ? SPAN_W'(1) : SPAN_W'(count);
            region    <= '0;
            scan_addr <= SPAN_W'(region_first[0]);
            run_len   <= '0;
            chk_valid <= 1'b0;
            if (op_t'(op) == OP_ADD_REF || op_t'(op) == OP_DROP_REF) begin
              state <= S_READ;
            end else if (op_t'(op) == OP_ALLOC_RUN && count == '0) begin
              done      <= 1'b1;
              status    <= ST_NO_SPACE;
              page_out  <= '0;
              refs_left <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chk_valid) begin
            run_len   <= page_free ? SPAN_W'(run_len + 1'b1) : '0;
            run_start <= cand_start;
          end
          if (run_found) begin
            chk_valid <= 1'b0;
            fill_addr <= cand_start;
            fill_left <= need;
            state     <= S_FILL;
          end else if (scan_more) begin
            chk_valid <= 1'b1;
            chk_addr  <= scan_addr[PAGE_W-1:0];
            scan_addr <= SPAN_W'(scan_addr + 1'b1);
          end else if (chk_valid) begin
            chk_valid <= 1'b0;
          end else if (region == REG_W'(REGIONS - 1)) begin
            done      <= 1'b1;
            status    <= ST_NO_SPACE;
            page_out  <= '0;
            refs_left <= '0;
            state     <= S_IDLE;
          end else begin
            region    <= REG_W'(region + 1'b1);
            scan_addr <= SPAN_W'(region_first[REG_W'(region + 1'b1)]);
            run_len   <= '0;
          end
        end
        S_FILL: begin
          fill_addr <= PAGE_W'(fill_addr + 1'b1);
          fill_left <= SPAN_W'(fill_left - 1'b1);
          if (fill_left == SPAN_W'(1)) begin
            done      <= 1'b1;
            status    <= ST_OK;
            page_out  <= run_start;
            refs_left <= REF_W'(1);
            state     <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          done     <= 1'b1;
          page_out <= '0;
          if (upd_bad) begin
            status    <= ST_BAD_PAGE;
            refs_left <= '0;
          end else if (upd_sat) begin
            status    <= ST_SAT;
            refs_left <= CNT_SAT;
          end else begin
            status    <= ST_OK;
            refs_left <= upd_value;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result strobe during the clearing pass");

  a_err_page_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (page_out == '0))
    else $error("page_out not zero on an error status");

  a_bad_refs_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_BAD_PAGE || status == ST_NO_SPACE)) |-> (refs_left == '0))
    else $error("refs_left not zero on an error status");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_SCAN || state == S_READ) |-> !ram_wr_en)
    else $error("count RAM written outside a write phase");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("block not busy after reset");

endmodule

>>> rtl/pfra_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> verif/page_frame_reply_checker.sv
`timescale 1ns / 100ps
// Reply checker for page_frame_refcount_allocator: mirrors the region registers
// and the per-page reference counts, predicts each reply beat and compares it.
// Depends on pfra_pkg only; instantiated beside the allocator by the test top.
module page_frame_reply_checker
  import pfra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        op,
  input  logic [PAGE_W-1:0] page,
  input  logic [CFG_W-1:0]  count,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [PAGE_W-1:0] page_out,
  input  logic [REF_W-1:0]  refs_left,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                mismatches,
  output int                replies_pending
);

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] first_page;
    logic [REF_W-1:0]  refs;
  } reply_t;

  logic [CFG_W-1:0] region_bound [2*REGIONS];
  logic [REF_W-1:0] page_refs [PAGES];
  reply_t           replies_due [$];
  reply_t           oldest;
  int               err_count = 0;

  function automatic int region_lo(int r);
    return int'(region_bound[2*r]);
  endfunction

  function automatic int region_hi(int r);
    int e;
    e = int'(region_bound[2*r+1]);
    return (e > PAGES) ? PAGES : e;
  endfunction

  function automatic bit page_in_region(int p);
    for (int r = 0; r < REGIONS; r++)
      if (p >= region_lo(r) && p < region_hi(r)) return 1'b1;
    return 1'b0;
  endfunction

  // First fit of n free pages, region by region; a run never crosses regions.
  function automatic bit find_free_run(int n, output int first);
    int run;
    first = 0;
    for (int r = 0; r < REGIONS; r++) begin
      run = 0;
      for (int j = region_lo(r); j < region_hi(r); j++) begin
        if (page_refs[j] == '0) begin
          if (run == 0) first = j;
          run++;
          if (run == n) return 1'b1;
        end else begin
          run = 0;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t frame_reply(logic [1:0] o, logic [PAGE_W-1:0] p,
                                         logic [CFG_W-1:0] n);
    reply_t           rep;
    int               want;
    int               base;
    bit               found;
    logic [REF_W-1:0] c;
    rep = '0;
    rep.status = ST_OK;
    if (o == OP_ALLOC_ONE || o == OP_ALLOC_RUN) begin
      want = (o == OP_ALLOC_ONE) ? 1 : int'(n);
      found = 1'b0;
      if (want != 0) found = find_free_run(want, base);
      if (!found) begin
        rep.status = ST_NO_SPACE;
      end else begin
        for (int k = 0; k < want && base + k < PAGES; k++) page_refs[base + k] = REF_W'(1);
        rep.first_page = PAGE_W'(base);
        rep.refs = REF_W'(1);
      end
    end else begin
      c = page_refs[p];
      if (!page_in_region(int'(p)) || c == '0 || c == CNT_RESERVED) begin
        rep.status = ST_BAD_PAGE;
      end else if (o == OP_ADD_REF) begin
        if (c == CNT_SAT) begin
          rep.status = ST_SAT;
          rep.refs = CNT_SAT;
        end else begin
          c = c + 1'b1;
          page_refs[p] = c;
          rep.refs = c;
        end
      end else begin
        c = c - 1'b1;
        page_refs[p] = c;
        rep.refs = c;
      end
    end
    return rep;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGES; i++) page_refs[i] = '0;
      for (int i = 0; i < 2*REGIONS; i++) region_bound[i] = '0;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < CFG_REGS) region_bound[cfg_index] = cfg_data;
      if (done) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply beat: status %0d page %0d refs %0d",
                   $time, status, page_out, refs_left);
          err_count++;
        end else begin
          oldest = replies_due.pop_front();
          if (status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time, oldest.status, status);
            err_count++;
          end
          if (page_out !== oldest.first_page) begin
            $display("%0t: page_out expected %0d actual %0d",
                     $time, oldest.first_page, page_out);
            err_count++;
          end
          if (refs_left !== oldest.refs) begin
            $display("%0t: refs_left expected %0d actual %0d", $time, oldest.refs, refs_left);
            err_count++;
          end
        end
      end
      if (start && !busy) replies_due.push_back(frame_reply(op, page, count));
    end
    mismatches <= err_count;
    replies_pending <= replies_due.size();
  end

endmodule

>>> verif/page_frame_refcount_allocator_test.sv
`timescale 1ns / 100ps
// Test top for page_frame_refcount_allocator: clock, reset, region setups,
// request traffic and the verdict. Depends on pfra_pkg, the allocator RTL
// and page_frame_reply_checker, which does all prediction and comparison.
module page_frame_refcount_allocator_test;
  import pfra_pkg::*;

  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int CYCLE_LIMIT = 4 * 150 * (5 * PAGES + 64) + PAGES;
  localparam logic [IDX_W-1:0] IDX_FIRST = '0;
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(1);

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        op = OP_ALLOC_ONE;
  logic [PAGE_W-1:0] page = '0;
  logic [CFG_W-1:0]  count = '0;
  logic              done;
  logic [1:0]        status;
  logic [PAGE_W-1:0] page_out;
  logic [REF_W-1:0]  refs_left;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  int                mismatches;
  int                replies_pending;

  int cycles = 0;
  int sent = 0;
  int setups = 0;
  bit gaps_on = 1'b1;
  int first_v [REGIONS];
  int end_v [REGIONS];

  page_frame_refcount_allocator dut (.*);
  page_frame_reply_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (replies_pending != 0 || busy);
  endtask

  task automatic issue_request(logic [1:0] o, int p, int n);
    if (gaps_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    start <= 1'b1;
    op <= o;
    page <= PAGE_W'(p);
    count <= CFG_W'(n);
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    if ($urandom_range(99) < 38) begin
      cfg_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regions();
    settle();
    for (int r = 0; r < REGIONS; r++) begin
      write_reg(IDX_FIRST + IDX_W'(2*r), first_v[r]);
      write_reg(IDX_END + IDX_W'(2*r), end_v[r]);
    end
    cfg_valid <= 1'b0;
    setups++;
  endtask

  function automatic int usable_end(int r);
    return (end_v[r] > PAGES) ? PAGES : end_v[r];
  endfunction

  // Mostly pages inside a configured region, sometimes anywhere.
  function automatic int pick_page();
    int r;
    r = $urandom_range(REGIONS-1);
    if ($urandom_range(99) < 80 && usable_end(r) > first_v[r])
      return first_v[r] + $urandom_range(usable_end(r) - first_v[r] - 1);
    return $urandom_range(PAGES-1);
  endfunction

  task automatic random_regions();
    int base;
    for (int r = 0; r < REGIONS; r++) begin
      base = $urandom_range(PAGES - 48);
      case ($urandom_range(9))
        0: begin
          first_v[r] = base;
          end_v[r] = base;
        end
        1: begin
          first_v[r] = base + 5;
          end_v[r] = base;
        end
        2: begin
          first_v[r] = PAGES - $urandom_range(1, 40);
          end_v[r] = CFG_MAX;
        end
        3: begin
          first_v[r] = (r > 0 && first_v[r-1] < PAGES - 48) ? first_v[r-1] + 2 : base;
          end_v[r] = first_v[r] + 20;
        end
        default: begin
          first_v[r] = base;
          end_v[r] = base + $urandom_range(1, 40);
        end
      endcase
    end
    program_regions();
  endtask

  task automatic random_request();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 25) begin
      issue_request(OP_ALLOC_ONE, $urandom_range(PAGES-1), $urandom_range(CFG_MAX));
    end else if (pick < 45) begin
      case ($urandom_range(9))
        0: n = 0;
        1: n = $urandom_range(CFG_MAX);
        2: n = $urandom_range(7, 48);
        default: n = $urandom_range(1, 6);
      endcase
      issue_request(OP_ALLOC_RUN, $urandom_range(PAGES-1), n);
    end else if (pick < 65) begin
      issue_request(OP_ADD_REF, pick_page(), $urandom_range(CFG_MAX));
    end else begin
      issue_request(OP_DROP_REF, pick_page(), $urandom_range(CFG_MAX));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Small, overlapping and empty regions.
    first_v = '{10, 12, 30, 40};
    end_v = '{14, 20, 30, 38};
    program_regions();
    write_reg(CFG_REGS + IDX_W'($urandom_range(2*REGIONS-1)), $urandom_range(CFG_MAX));
    cfg_valid <= 1'b0;
    issue_request(OP_ADD_REF, 5, 0);
    issue_request(OP_ADD_REF, 10, 0);
    issue_request(OP_DROP_REF, 11, CFG_MAX);
    issue_request(OP_ALLOC_RUN, 0, 0);
    issue_request(OP_ALLOC_ONE, PAGES-1, 0);
    issue_request(OP_ALLOC_RUN, 0, 3);
    issue_request(OP_ALLOC_RUN, 0, 5);
    issue_request(OP_ALLOC_RUN, 0, 20);
    issue_request(OP_ALLOC_RUN, 0, CFG_MAX);
    issue_request(OP_ADD_REF, 10, 0);
    issue_request(OP_DROP_REF, 10, 0);
    issue_request(OP_DROP_REF, 10, 0);
    issue_request(OP_ALLOC_ONE, 0, 0);
    issue_request(OP_DROP_REF, 0, 0);
    issue_request(OP_ADD_REF, PAGES-1, 0);
    issue_request(OP_DROP_REF, 11, 0);
    settle();

    // Whole store in one region with a clipped end, plus a top slice.
    first_v = '{0, CFG_MAX, 4000, 0};
    end_v = '{CFG_MAX, 0, PAGES, 0};
    program_regions();
    issue_request(OP_ALLOC_RUN, 0, PAGES);
    issue_request(OP_ALLOC_RUN, 0, 4000);
    issue_request(OP_ALLOC_ONE, 0, 0);
    issue_request(OP_ADD_REF, PAGES-1, 0);
    issue_request(OP_DROP_REF, PAGES-1, 0);
    issue_request(OP_DROP_REF, PAGES-1, 0);
    issue_request(OP_ALLOC_ONE, 0, 0);
    issue_request(OP_ALLOC_RUN, 0, 1);
    for (int i = 0; i < 6; i++) random_request();

    for (int ph = 0; ph < 4; ph++) begin
      random_regions();
      gaps_on = (ph != 2);
      for (int i = 0; i < 27; i++) begin
        random_request();
        if ($urandom_range(29) == 0) settle();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("Ran %0d requests over %0d region setups: directed corner cases,",
             sent, setups);
    $display("whole-store scans and random traffic over overlapping, empty and clipped regions.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> page_frame_refcount_allocator.f
rtl/pfra_pkg.sv
rtl/pfra_ram.sv
rtl/page_frame_refcount_allocator.sv
verif/page_frame_reply_checker.sv
verif/page_frame_refcount_allocator_test.sv
